// File: src/fba_pkg.sv
// Shared types, constants and float compare helpers for the bias and activation unit.
package fba_pkg;

   localparam int LANES_DEF = 4;
   localparam int FP_W = 32;
   localparam int CNT_W = 3;
   localparam int IDX_W = 3;
   localparam int ACT_W = 3;
   // Pipeline steps from an accepted beat to its result in the output register.
   localparam int LAT = 10;

   localparam logic [ACT_W-1:0] ACT_IDENTITY = 3'd0;
   localparam logic [ACT_W-1:0] ACT_RELU     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LEAKY    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLIP     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_HSIG     = 3'd4;

   localparam logic [IDX_W-1:0] REG_ACT      = 3'd0;
   localparam logic [IDX_W-1:0] REG_BIAS_EN  = 3'd1;
   localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd2;
   localparam logic [IDX_W-1:0] REG_BETA     = 3'd3;
   localparam logic [IDX_W-1:0] REG_CLIP_MIN = 3'd4;
   localparam logic [IDX_W-1:0] REG_CLIP_MAX = 3'd5;

   localparam logic [FP_W-1:0] FP_ZERO = 32'h0000_0000;
   localparam logic [FP_W-1:0] FP_ONE  = 32'h3F80_0000;
   localparam logic [FP_W-1:0] FP_QNAN = 32'hFFC0_0000;
   localparam logic [FP_W-1:0] FP_QUIET = 32'h0040_0000;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             bias_en;
      logic [FP_W-1:0]  alpha;
      logic [FP_W-1:0]  beta;
      logic [FP_W-1:0]  lo;
      logic [FP_W-1:0]  hi;
   } cfg_type;

   function automatic logic is_nan(input logic [FP_W-1:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [FP_W-1:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [FP_W-1:0] a);
      return a[30:0] == 31'd0;
   endfunction

   // Ordered a > b; false when either side is NaN, and signed zeros compare equal.
   function automatic logic fp_gt(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
      logic r;
      if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) begin
         r = 1'b0;
      end else if (a[31] != b[31]) begin
         r = !a[31];
      end else if (!a[31]) begin
         r = a[30:0] > b[30:0];
      end else begin
         r = a[30:0] < b[30:0];
      end
      return r;
   endfunction

   // True when a >= 0, negative zero included.
   function automatic logic fp_ge_zero(input logic [FP_W-1:0] a);
      return !is_nan(a) && (!a[31] || is_zero(a));
   endfunction

endpackage

// File: src/fba_fadd.sv
// Three-stage IEEE single-precision adder, round to nearest even.
module fba_fadd (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // Stage 1: specials, operand swap and alignment.
   logic [7:0]  ea, eb, e_big, e_small, diff;
   logic [23:0] sig_a, sig_b, sig_big, sig_small;
   logic [5:0]  dsat;
   logic [49:0] ext;
   logic        a_big, spec;
   logic [31:0] spec_val;

   logic        s1_sign_ff, s1_sub_ff, s1_spec_ff;
   logic [7:0]  s1_exp_ff;
   logic [26:0] s1_big_ff, s1_small_ff;
   logic [31:0] s1_spec_val_ff;

   always_comb begin
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      sig_a = {a[30:23] != 8'd0, a[22:0]};
      sig_b = {b[30:23] != 8'd0, b[22:0]};
      a_big = a[30:0] >= b[30:0];
      e_big = a_big ? ea : eb;
      e_small = a_big ? eb : ea;
      sig_big = a_big ? sig_a : sig_b;
      sig_small = a_big ? sig_b : sig_a;
      diff = e_big - e_small;
      // Beyond 49 every bit of the smaller operand already lands in the sticky field.
      dsat = (diff > 8'd49) ? 6'd49 : diff[5:0];
      ext = {sig_small, 26'd0} >> dsat;

      spec = 1'b1;
      spec_val = fba_pkg::FP_QNAN;
      if (fba_pkg::is_nan(a)) begin
         spec_val = a | fba_pkg::FP_QUIET;
      end else if (fba_pkg::is_nan(b)) begin
         spec_val = b | fba_pkg::FP_QUIET;
      end else if (fba_pkg::is_inf(a) && fba_pkg::is_inf(b) && (a[31] != b[31])) begin
         spec_val = fba_pkg::FP_QNAN;
      end else if (fba_pkg::is_inf(a)) begin
         spec_val = a;
      end else if (fba_pkg::is_inf(b)) begin
         spec_val = b;
      end else begin
         spec = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sign_ff <= a_big ? a[31] : b[31];
         s1_sub_ff <= a[31] ^ b[31];
         s1_exp_ff <= e_big;
         s1_big_ff <= {sig_big, 3'd0};
         s1_small_ff <= {ext[49:24], |ext[23:0]};
         s1_spec_ff <= spec;
         s1_spec_val_ff <= spec_val;
      end
   end

   // Stage 2: add or subtract, then find the normalizing shift.
   logic [27:0] sum_in;
   logic [4:0]  lz, shl;
   logic [7:0]  em1;
   logic [27:0] s2_sum_ff;
   logic [4:0]  s2_shl_ff;
   logic [7:0]  s2_exp_ff;
   logic        s2_sign_ff, s2_spec_ff;
   logic [31:0] s2_spec_val_ff;

   always_comb begin
      sum_in = s1_sub_ff ? ({1'b0, s1_big_ff} - {1'b0, s1_small_ff})
                         : ({1'b0, s1_big_ff} + {1'b0, s1_small_ff});
      lz = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (sum_in[i]) begin
            lz = 5'(26 - i);
         end
      end
      // Stop the left shift where the exponent would fall below the subnormal range.
      em1 = s1_exp_ff - 8'd1;
      shl = ({3'd0, lz} < em1) ? lz : em1[4:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sum_ff <= sum_in;
         s2_shl_ff <= shl;
         s2_exp_ff <= s1_exp_ff;
         // An exact cancellation gives positive zero.
         s2_sign_ff <= (sum_in == 28'd0 && s1_sub_ff) ? 1'b0 : s1_sign_ff;
         s2_spec_ff <= s1_spec_ff;
         s2_spec_val_ff <= s1_spec_val_ff;
      end
   end

   // Stage 3: normalize and round.
   logic [26:0] m;
   logic [7:0]  e, field;
   logic        up;
   logic [30:0] rounded;
   logic [31:0] y_in, y_ff;

   always_comb begin
      if (s2_sum_ff[27]) begin
         m = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         e = s2_exp_ff + 8'd1;
      end else begin
         m = s2_sum_ff[26:0] << s2_shl_ff;
         e = s2_exp_ff - {3'd0, s2_shl_ff};
      end
      field = m[26] ? e : 8'd0;
      up = m[2] & (m[1] | m[0] | m[3]);
      rounded = {field, m[25:3]} + {30'd0, up};
      if (s2_spec_ff) begin
         y_in = s2_spec_val_ff;
      end else if (e == 8'hFF) begin
         y_in = {s2_sign_ff, 8'hFF, 23'd0};
      end else begin
         y_in = {s2_sign_ff, rounded};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// File: src/fba_fmul.sv
// Three-stage IEEE single-precision multiplier, round to nearest even.
module fba_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // Stage 1: significand product and exponent of its top bit.
   logic [7:0]  ea, eb;
   logic        spec;
   logic [31:0] spec_val;
   logic        sign;

   logic [47:0]        s1_prod_ff;
   logic signed [10:0] s1_exp_ff;
   logic               s1_sign_ff, s1_spec_ff;
   logic [31:0]        s1_spec_val_ff;

   always_comb begin
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      sign = a[31] ^ b[31];
      spec = 1'b1;
      spec_val = fba_pkg::FP_QNAN;
      if (fba_pkg::is_nan(a)) begin
         spec_val = a | fba_pkg::FP_QUIET;
      end else if (fba_pkg::is_nan(b)) begin
         spec_val = b | fba_pkg::FP_QUIET;
      end else if ((fba_pkg::is_inf(a) && fba_pkg::is_zero(b))
                   || (fba_pkg::is_inf(b) && fba_pkg::is_zero(a))) begin
         spec_val = fba_pkg::FP_QNAN;
      end else if (fba_pkg::is_inf(a) || fba_pkg::is_inf(b)) begin
         spec_val = {sign, 8'hFF, 23'd0};
      end else if (fba_pkg::is_zero(a) || fba_pkg::is_zero(b)) begin
         spec_val = {sign, 31'd0};
      end else begin
         spec = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
         s1_exp_ff <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
         s1_sign_ff <= sign;
         s1_spec_ff <= spec;
         s1_spec_val_ff <= spec_val;
      end
   end

   // Stage 2: leading zero count of the product.
   logic [5:0]         lz;
   logic [47:0]        s2_prod_ff;
   logic [5:0]         s2_lz_ff;
   logic signed [10:0] s2_exp_ff;
   logic               s2_sign_ff, s2_spec_ff;
   logic [31:0]        s2_spec_val_ff;

   always_comb begin
      lz = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (s1_prod_ff[i]) begin
            lz = 6'(47 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_prod_ff <= s1_prod_ff;
         s2_lz_ff <= lz;
         s2_exp_ff <= s1_exp_ff;
         s2_sign_ff <= s1_sign_ff;
         s2_spec_ff <= s1_spec_ff;
         s2_spec_val_ff <= s1_spec_val_ff;
      end
   end

   // Stage 3: normalize, or denormalize into the subnormal range, and round.
   logic signed [10:0] el, rr;
   logic [5:0]         rsh;
   logic [95:0]        ext;
   logic [47:0]        m;
   logic               sticky, up;
   logic signed [10:0] e;
   logic [7:0]         field;
   logic [30:0]        rounded;
   logic [31:0]        y_in, y_ff;

   always_comb begin
      el = s2_exp_ff - $signed({5'd0, s2_lz_ff});
      rr = 11'sd1 - s2_exp_ff;
      rsh = (rr > 11'sd48) ? 6'd48 : rr[5:0];
      ext = {s2_prod_ff, 48'd0} >> rsh;
      sticky = 1'b0;
      e = 11'sd1;
      if (el >= 11'sd1) begin
         m = s2_prod_ff << s2_lz_ff;
         e = el;
      end else if (s2_exp_ff >= 11'sd1) begin
         m = s2_prod_ff << 6'(s2_exp_ff - 11'sd1);
      end else begin
         m = ext[95:48];
         sticky = |ext[47:0];
      end
      field = m[47] ? e[7:0] : 8'd0;
      up = m[23] & ((|m[22:0]) | sticky | m[24]);
      rounded = {field, m[46:24]} + {30'd0, up};
      if (s2_spec_ff) begin
         y_in = s2_spec_val_ff;
      end else if (e >= 11'sd255) begin
         y_in = {s2_sign_ff, 8'hFF, 23'd0};
      end else begin
         y_in = {s2_sign_ff, rounded};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// File: src/fba_lane.sv
// One lane: bias add, activation arithmetic and the final select.
module fba_lane (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     active,
   input  logic [31:0]              value,
   input  logic [31:0]              bias,
   input  fba_pkg::cfg_type         cfg,
   output logic [31:0]              result
);

   localparam int PIPE = fba_pkg::LAT - 1;

   logic [31:0] orig_ff [PIPE];
   logic        act_ff [PIPE];
   logic [31:0] x_ff [6];
   logic [31:0] m_ff [3];
   logic [31:0] biased, x, prod, affine;

   fba_fadd u_bias_add (
      .clock (clock),
      .en    (en),
      .a     (value),
      .b     (bias),
      .y     (biased)
   );

   // The bias sum leaves the adder in step with orig_ff[2], the delayed copy of the unbiased value.
   assign x = cfg.bias_en ? biased : orig_ff[2];

   fba_fmul u_scale (
      .clock (clock),
      .en    (en),
      .a     (x),
      .b     (cfg.alpha),
      .y     (prod)
   );

   fba_fadd u_offset (
      .clock (clock),
      .en    (en),
      .a     (prod),
      .b     (cfg.beta),
      .y     (affine)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         orig_ff[0] <= value;
         act_ff[0] <= active;
         for (int i = 1; i < PIPE; i++) begin
            orig_ff[i] <= orig_ff[i-1];
            act_ff[i] <= act_ff[i-1];
         end
         x_ff[0] <= x;
         for (int i = 1; i < 6; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         m_ff[0] <= prod;
         for (int i = 1; i < 3; i++) begin
            m_ff[i] <= m_ff[i-1];
         end
      end
   end

   logic [31:0] xs, t, act_val, result_in, result_ff;

   always_comb begin
      xs = x_ff[5];
      t = xs;
      case (cfg.act)
         fba_pkg::ACT_RELU: begin
            act_val = fba_pkg::fp_gt(fba_pkg::FP_ZERO, xs) ? fba_pkg::FP_ZERO : xs;
         end
         fba_pkg::ACT_LEAKY: begin
            act_val = fba_pkg::fp_ge_zero(xs) ? xs : m_ff[2];
         end
         fba_pkg::ACT_CLIP: begin
            t = fba_pkg::fp_gt(cfg.lo, xs) ? cfg.lo : xs;
            act_val = fba_pkg::fp_gt(t, cfg.hi) ? cfg.hi : t;
         end
         fba_pkg::ACT_HSIG: begin
            t = fba_pkg::fp_gt(affine, fba_pkg::FP_ONE) ? fba_pkg::FP_ONE : affine;
            act_val = fba_pkg::fp_gt(fba_pkg::FP_ZERO, t) ? fba_pkg::FP_ZERO : t;
         end
         default: begin
            act_val = xs;
         end
      endcase
      result_in = act_ff[PIPE-1] ? act_val : orig_ff[PIPE-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/fused_bias_activation.sv
// Top level of the fused bias-add and activation unit.
// Each input beat carries LANES fp32 values of one row, the row bias and a lane count; one
// result beat leaves per input beat, and a new beat is taken every cycle while the result
// side keeps up. The delay is set by the lane pipeline: a three-stage bias adder, a three-stage
// multiplier and a three-stage adder for the hard sigmoid offset, then a select stage into the
// output register. The whole pipeline holds when a finished result is not taken. The user must
// write configuration through the csr port while no beat is in flight; the unit does not check.
module fused_bias_activation #(
   parameter int LANES = fba_pkg::LANES_DEF
) (
   input  logic clock,
   input  logic reset,
   // lanes 0..LANES-1 value, row_bias, lane_count (from bit 0 up), zero padded
   input  logic [((LANES*32+32+fba_pkg::CNT_W+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // lanes 0..LANES-1 result, result_count (from bit 0 up), zero padded
   output logic [((LANES*32+fba_pkg::CNT_W+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_we,
   input  logic [fba_pkg::IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int LAT = fba_pkg::LAT;
   localparam int CW = fba_pkg::CNT_W;
   localparam int OUT_W = ((LANES*32+CW+7)/8)*8;

   fba_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fba_pkg::REG_ACT:      cfg_ff.act <= csr_wdata[fba_pkg::ACT_W-1:0];
            fba_pkg::REG_BIAS_EN:  cfg_ff.bias_en <= csr_wdata[0];
            fba_pkg::REG_ALPHA:    cfg_ff.alpha <= csr_wdata;
            fba_pkg::REG_BETA:     cfg_ff.beta <= csr_wdata;
            fba_pkg::REG_CLIP_MIN: cfg_ff.lo <= csr_wdata;
            fba_pkg::REG_CLIP_MAX: cfg_ff.hi <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic          adv;
   logic          valid_ff [LAT];
   logic [CW-1:0] cnt_ff [LAT];
   logic [CW-1:0] cnt_in;
   logic [31:0]   bias_in;

   // Every stage moves together; it holds only while a result waits at the output.
   assign adv = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign cnt_in = req_tdata[LANES*32+32 +: CW];
   assign bias_in = req_tdata[LANES*32 +: 32];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt_ff[0] <= cnt_in;
         for (int i = 1; i < LAT; i++) begin
            cnt_ff[i] <= cnt_ff[i-1];
         end
      end
   end

   logic [LANES*32-1:0] results;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fba_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .active (32'(g) < 32'(cnt_in)),
         .value  (req_tdata[g*32 +: 32]),
         .bias   (bias_in),
         .cfg    (cfg_ff),
         .result (results[g*32 +: 32])
      );
   end

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata = OUT_W'({cnt_ff[LAT-1], results});

endmodule

// File: bench/tb_fused_bias_activation.sv
// Testbench for the fused bias-add and activation unit: directed and random rows checked lane by lane.
`timescale 1ns / 1ps

module tb_fused_bias_activation;

   localparam int LANES = fba_pkg::LANES_DEF;
   localparam int REQ_W = ((LANES*32+32+fba_pkg::CNT_W+7)/8)*8;
   localparam int RSP_W = ((LANES*32+fba_pkg::CNT_W+7)/8)*8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [fba_pkg::IDX_W-1:0] REG_SPARE6 = 3'd6;
   localparam logic [fba_pkg::IDX_W-1:0] REG_SPARE7 = 3'd7;
   localparam logic [fba_pkg::ACT_W-1:0] ACT_SPARE5 = 3'd5;
   localparam logic [fba_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;
   localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [fba_pkg::IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Local copy of the configuration registers.
   logic [fba_pkg::ACT_W-1:0] act_sel;
   logic bias_on;
   logic [31:0] alpha_fp, beta_fp, lo_fp, hi_fp;

   logic [RSP_W-1:0] expected_rows[$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   fused_bias_activation #(.LANES(LANES)) uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** fused_bias_activation: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= recv_idle);

   // ---------------- single-precision arithmetic ----------------

   function automatic logic fp_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 0);
   endfunction

   function automatic logic fp_infinite(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 0);
   endfunction

   function automatic real fp_to_real(input logic [31:0] a);
      int e;
      logic [23:0] man;
      logic [63:0] d;
      man = {1'b0, a[22:0]};
      if (a[30:23] == 8'h00) begin
         if (man == 0) begin
            d = {a[31], 63'd0};
         end else begin
            e = -126;
            while (!man[23]) begin
               man = man << 1;
               e = e - 1;
            end
            d = {a[31], 11'(e + 1023), man[22:0], 29'd0};
         end
      end else if (a[30:23] == 8'hFF) begin
         d = {a[31], 11'h7FF, a[22:0], 29'd0};
      end else begin
         d = {a[31], 11'(int'(a[30:23]) - 127 + 1023), a[22:0], 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   // Rounds a double (never NaN here) to single precision, nearest even.
   function automatic logic [31:0] real_to_fp(input real r);
      logic [63:0] b, sig, keep, rem, half;
      int e, sh;
      b = $realtobits(r);
      if (b[62:0] == 0) return {b[63], 31'd0};
      if (b[62:52] == 11'h7FF) return {b[63], 8'hFF, 23'd0};
      e = int'(b[62:52]) - 1023 + 127;
      sig = {11'd0, 1'b1, b[51:0]};
      sh = (e >= 1) ? 29 : 30 - e;
      if (sh >= 64) return {b[63], 31'd0};
      keep = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      if (e >= 1) begin
         if (keep[24]) begin
            keep = keep >> 1;
            e = e + 1;
         end
         if (e >= 255) return {b[63], 8'hFF, 23'd0};
         return {b[63], 8'(e), keep[22:0]};
      end
      // A subnormal that rounds up to the smallest normal carries into the exponent.
      return {b[63], keep[30:0]};
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      if (fp_nan(a)) return a | QUIET_BIT;
      if (fp_nan(b)) return b | QUIET_BIT;
      if (fp_infinite(a) && fp_infinite(b) && a[31] != b[31]) return DEFAULT_NAN;
      return real_to_fp(fp_to_real(a) + fp_to_real(b));
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      if (fp_nan(a)) return a | QUIET_BIT;
      if (fp_nan(b)) return b | QUIET_BIT;
      if ((fp_infinite(a) && b[30:0] == 0) || (fp_infinite(b) && a[30:0] == 0))
         return DEFAULT_NAN;
      return real_to_fp(fp_to_real(a) * fp_to_real(b));
   endfunction

   function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
      if (fp_nan(a) || fp_nan(b)) return 1'b0;
      return fp_to_real(a) > fp_to_real(b);
   endfunction

   function automatic logic [31:0] activate_lane(input logic [31:0] x);
      logic [31:0] t;
      case (act_sel)
         fba_pkg::ACT_RELU: return fp_greater(fba_pkg::FP_ZERO, x) ? fba_pkg::FP_ZERO : x;
         fba_pkg::ACT_LEAKY: begin
            t = fp_mul(x, alpha_fp);
            return (!fp_nan(x) && !fp_greater(fba_pkg::FP_ZERO, x)) ? x : t;
         end
         fba_pkg::ACT_CLIP: begin
            t = fp_greater(lo_fp, x) ? lo_fp : x;
            return fp_greater(t, hi_fp) ? hi_fp : t;
         end
         fba_pkg::ACT_HSIG: begin
            t = fp_add(fp_mul(x, alpha_fp), beta_fp);
            t = fp_greater(t, fba_pkg::FP_ONE) ? fba_pkg::FP_ONE : t;
            return fp_greater(fba_pkg::FP_ZERO, t) ? fba_pkg::FP_ZERO : t;
         end
         default: return x;
      endcase
   endfunction

   function automatic logic [RSP_W-1:0] predict_row(input logic [REQ_W-1:0] d);
      logic [RSP_W-1:0] r;
      logic [fba_pkg::CNT_W-1:0] cnt;
      logic [31:0] v;
      int used;
      r = '0;
      cnt = d[LANES*32+32 +: fba_pkg::CNT_W];
      used = (cnt > LANES) ? LANES : cnt;
      for (int i = 0; i < LANES; i++) begin
         v = d[i*32 +: 32];
         if (i < used) begin
            if (bias_on) v = fp_add(v, d[LANES*32 +: 32]);
            v = activate_lane(v);
         end
         r[i*32 +: 32] = v;
      end
      r[LANES*32 +: fba_pkg::CNT_W] = cnt;
      return r;
   endfunction

   // ---------------- monitors ----------------

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) expected_rows.push_back(predict_row(req_tdata));
   end

   always @(posedge clock) begin
      logic [RSP_W-1:0] exp_row;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            errors = errors + 1;
         end else begin
            exp_row = expected_rows.pop_front();
            for (int i = 0; i < LANES; i++) begin
               if (rsp_tdata[i*32 +: 32] !== exp_row[i*32 +: 32]) begin
                  $display("%0t: lane %0d expected %h actual %h", $time, i,
                           exp_row[i*32 +: 32], rsp_tdata[i*32 +: 32]);
                  errors = errors + 1;
               end
            end
            if (rsp_tdata[LANES*32 +: fba_pkg::CNT_W] !== exp_row[LANES*32 +: fba_pkg::CNT_W])
            begin
               $display("%0t: count expected %0d actual %0d", $time,
                        exp_row[LANES*32 +: fba_pkg::CNT_W],
                        rsp_tdata[LANES*32 +: fba_pkg::CNT_W]);
               errors = errors + 1;
            end
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   // Entered and left at a rising edge.
   task automatic send_row(input logic [31:0] l0, input logic [31:0] l1, input logic [31:0] l2,
                           input logic [31:0] l3, input logic [31:0] bias,
                           input logic [fba_pkg::CNT_W-1:0] cnt);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({cnt, bias, l3, l2, l1, l0});
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      // Wait for a rising edge so the last accepted beat is already queued.
      @(posedge clock);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (fba_pkg::LAT + 5) @(posedge clock);
   endtask

   task automatic write_reg(input logic [fba_pkg::IDX_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         fba_pkg::REG_ACT: act_sel = val[fba_pkg::ACT_W-1:0];
         fba_pkg::REG_BIAS_EN: bias_on = val[0];
         fba_pkg::REG_ALPHA: alpha_fp = val;
         fba_pkg::REG_BETA: beta_fp = val;
         fba_pkg::REG_CLIP_MIN: lo_fp = val;
         fba_pkg::REG_CLIP_MAX: hi_fp = val;
         default: ;
      endcase
   endtask

   task automatic apply_cfg(input logic [fba_pkg::ACT_W-1:0] act, input logic [31:0] ben,
                            input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] lo, input logic [31:0] hi);
      drain();
      write_reg(fba_pkg::REG_ACT, 32'(act));
      write_reg(fba_pkg::REG_BIAS_EN, ben);
      write_reg(fba_pkg::REG_ALPHA, a);
      write_reg(fba_pkg::REG_BETA, b);
      write_reg(fba_pkg::REG_CLIP_MIN, lo);
      write_reg(fba_pkg::REG_CLIP_MAX, hi);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_fp();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h7FC0_0000;
            5: return 32'hFF80_0001;
            6: return 32'h0000_0001;
            7: return 32'h7F7F_FFFF;
            8: return 32'h3F80_0000;
            default: return 32'hBF80_0000;
         endcase
      end
      if (pick < 30) return $urandom();
      return {1'($urandom()), 8'($urandom_range(100, 150)), 23'($urandom())};
   endfunction

   // ---------------- tests ----------------

   task automatic test_identity_bias;
      apply_cfg(fba_pkg::ACT_IDENTITY, 1, 0, 0, 0, 0);
      send_row(32'h3F80_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000, 3'd4);
      send_row(32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001, 32'h7F80_0001, 32'hFF80_0000, 3'd4);
      send_row(32'h7F7F_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0080_0000, 32'h7F7F_FFFF, 3'd3);
      send_row(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h4000_0000, 3'd0);
      send_row(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'hBF80_0000, 3'd5);
      send_row(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h8000_0000, 3'd7);
   endtask

   task automatic test_relu;
      apply_cfg(fba_pkg::ACT_RELU, 0, 0, 0, 0, 0);
      send_row(32'h8000_0000, 32'h0000_0000, 32'h7FC0_0000, 32'hBF80_0000, 32'h0, 3'd4);
      send_row(32'hFF80_0000, 32'h7F80_0000, 32'h8000_0001, 32'hFFC0_0001, 32'h0, 3'd4);
   endtask

   task automatic test_leaky;
      apply_cfg(fba_pkg::ACT_LEAKY, 0, 32'h3C23_D70A, 0, 0, 0);
      send_row(32'hBF80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h8000_0000, 32'h0, 3'd4);
      send_row(32'h8080_0000, 32'h4120_0000, 32'hFF7F_FFFF, 32'h0000_0000, 32'h0, 3'd4);
      apply_cfg(fba_pkg::ACT_LEAKY, 1, 32'h7F80_0000, 0, 0, 0);
      send_row(32'h8000_0000, 32'hBF80_0000, 32'h0000_0000, 32'h3F80_0000, 32'h8000_0000, 3'd4);
   endtask

   task automatic test_clip;
      apply_cfg(fba_pkg::ACT_CLIP, 0, 0, 0, 32'hBF80_0000, 32'h3F80_0000);
      send_row(32'hFF80_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'h8000_0000, 32'h0, 3'd4);
      send_row(32'h3F00_0000, 32'hC000_0000, 32'h4000_0000, 32'h0000_0000, 32'h0, 3'd4);
      // Inverted bounds: the upper bound wins.
      apply_cfg(fba_pkg::ACT_CLIP, 0, 0, 0, 32'h7F80_0000, 32'hFF80_0000);
      send_row(32'h3F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0000, 32'h0, 3'd4);
   endtask

   task automatic test_hard_sigmoid;
      apply_cfg(fba_pkg::ACT_HSIG, 1, 32'h3E4C_CCCD, 32'h3F00_0000, 0, 0);
      send_row(32'h0000_0000, 32'h4020_0000, 32'hC020_0000, 32'h3F80_0000, 32'h0, 3'd4);
      send_row(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h4120_0000, 32'hBF80_0000, 3'd4);
      apply_cfg(fba_pkg::ACT_HSIG, 0, 32'h0000_0000, 32'hFF80_0000, 0, 0);
      send_row(32'h7F80_0000, 32'h3F80_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'h0, 3'd4);
   endtask

   task automatic test_spare_codes;
      apply_cfg(ACT_SPARE5, 1, 0, 0, 0, 0);
      write_reg(REG_SPARE6, 32'hFFFF_FFFF);
      write_reg(REG_SPARE7, 32'hFFFF_FFFF);
      csr_we <= 1'b0;
      @(posedge clock);
      send_row(32'hBF80_0000, 32'h3F80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h3F80_0000, 3'd4);
      apply_cfg(ACT_SPARE7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_row(32'hBF80_0000, 32'h3F80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h3F80_0000, 3'd6);
   endtask

   task automatic test_random(input int sidle, input int ridle);
      logic [fba_pkg::ACT_W-1:0] act;
      logic [fba_pkg::CNT_W-1:0] cnt;
      send_idle = sidle;
      recv_idle = ridle;
      for (int ph = 0; ph < 5; ph++) begin
         act = ($urandom_range(0, 9) == 0) ? fba_pkg::ACT_W'($urandom_range(5, 7))
                                            : fba_pkg::ACT_W'($urandom_range(0, 4));
         if (ph == 0) act = fba_pkg::ACT_HSIG;
         apply_cfg(act, $urandom_range(0, 1), rand_fp(), rand_fp(), rand_fp(), rand_fp());
         for (int n = 0; n < 50; n++) begin
            cnt = ($urandom_range(0, 4) == 0) ? fba_pkg::CNT_W'($urandom_range(0, 7))
                                               : fba_pkg::CNT_W'($urandom_range(1, 4));
            send_row(rand_fp(), rand_fp(), rand_fp(), rand_fp(), rand_fp(), cnt);
         end
      end
   endtask

   initial begin
      act_sel = fba_pkg::ACT_IDENTITY;
      bias_on = 1'b0;
      alpha_fp = '0;
      beta_fp = '0;
      lo_fp = '0;
      hi_fp = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_bias();
      test_relu();
      test_leaky();
      test_clip();
      test_hard_sigmoid();
      test_spare_codes();
      test_random(32, 53);
      test_random(53, 32);
      test_random(0, 0);
      drain();
      if (errors == 0) begin
         $display("** fused_bias_activation: PASSED **");
      end else begin
         $display("** fused_bias_activation: FAILED **");
      end
      $finish;
   end

endmodule
